FILE: src/ccmp_aad_nonce_builder_assert.svh
// assertion macros for the ccmp aad and nonce builder
`ifndef CCMP_AAD_NONCE_BUILDER_ASSERT_SVH
`define CCMP_AAD_NONCE_BUILDER_ASSERT_SVH

// clocked assertion, switched off while reset is low
`define CCMP_ANB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must hold whenever a valid flag is high
`define CCMP_ANB_ASSERT_ON_VALID(lbl, clk, rst_n, vld, cond, msg) \
  `CCMP_ANB_ASSERT(lbl, clk, rst_n, (vld) |-> (cond), msg)

`endif

FILE: src/ccmp_anb_pkg.sv
package ccmp_anb_pkg;

  localparam int unsigned InDataW  = 360;
  localparam int unsigned OutDataW = 472;

  typedef enum logic {
    ActTx = 1'b0,
    ActRx = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    TypeMgmt  = 2'd0,
    TypeCtrl  = 2'd1,
    TypeData  = 2'd2,
    TypeResvd = 2'd3
  } frame_type_e;

  localparam logic [15:0] FcSubtypeLow = 16'h0070;
  localparam logic [15:0] FcRetry      = 16'h0800;
  localparam logic [15:0] FcPwrMgt     = 16'h1000;
  localparam logic [15:0] FcMoreData   = 16'h2000;
  localparam logic [15:0] FcProtected  = 16'h4000;
  localparam logic [15:0] FcOrder      = 16'h8000;
  localparam logic [15:0] FcBothDs     = 16'h0300;
  localparam logic [3:0]  SubtypeQos   = 4'h8;
  localparam logic [7:0]  MgmtFlags    = 8'h10;
  localparam logic [4:0]  AadBaseLen   = 5'd22;
  localparam logic [4:0]  AddrLen      = 5'd6;
  localparam logic [4:0]  QosLen       = 5'd2;
  localparam logic [5:0]  HdrExtra     = 6'd2;

  // one request as it arrives
  typedef struct packed {
    action_e     action;
    logic [15:0] frame_control;
    logic [47:0] address_one;
    logic [47:0] address_two;
    logic [47:0] address_three;
    logic [47:0] address_four;
    logic [15:0] sequence_control;
    logic [15:0] qos_control;
    logic [47:0] packet_number;
    logic [1:0]  key_index;
    logic [63:0] ccmp_header_in;
  } in_t;

  // after header decode and ccmp header handling
  typedef struct packed {
    logic [15:0] masked_fc;
    logic [47:0] a1;
    logic [47:0] a2;
    logic [47:0] a3;
    logic [47:0] a4;
    logic [3:0]  frag;
    logic [3:0]  tid;
    logic        four;
    logic        qos;
    logic [7:0]  flags;
    logic [47:0] pn;
    logic [63:0] hdr_out;
    logic [47:0] pnum;
    logic [1:0]  pkey;
    logic        ok;
  } dec_t;

  // aad assembled, nonce still to be laid out
  typedef struct packed {
    logic [239:0] aad;
    logic [4:0]   aad_len;
    logic [5:0]   hdr_len;
    logic [47:0]  a2;
    logic [7:0]   flags;
    logic [47:0]  pn;
    logic [63:0]  hdr_out;
    logic [47:0]  pnum;
    logic [1:0]   pkey;
    logic         ok;
  } mid_t;

  // one finished result
  typedef struct packed {
    logic [63:0] aad_word0;
    logic [63:0] aad_word1;
    logic [63:0] aad_word2;
    logic [47:0] aad_word3;
    logic [4:0]  aad_length;
    logic [63:0] nonce_low;
    logic [39:0] nonce_high;
    logic [5:0]  header_length;
    logic [63:0] ccmp_header_out;
    logic [47:0] parsed_number;
    logic [1:0]  parsed_key;
    logic        header_ok;
  } res_t;

endpackage

FILE: src/ccmp_aad_nonce_builder.sv
// ccmp aad and nonce builder, three register stages: decode, aad assembly, nonce and output
// an accepted request passes the decode, assembly and output registers in order to the master side
// throughput: one request per cycle while the master side is ready; each stage moves on when the one after it is free
// a stalled output holds its result while the stages behind keep filling
// reset: asynchronous, active low, clears the stage valid flags only
module ccmp_aad_nonce_builder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // frame_control, address_one, address_two, address_three, address_four,
  // sequence_control, qos_control, packet_number, key_index, ccmp_header_in, zero fill
  input  logic [ccmp_anb_pkg::InDataW-1:0]    s_axis_tdata,
  // action
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // aad_word0, aad_word1, aad_word2, aad_word3, aad_length, nonce_low, nonce_high,
  // header_length, ccmp_header_out, parsed_number, parsed_key, header_ok, zero fill
  output logic [ccmp_anb_pkg::OutDataW-1:0]   m_axis_tdata
);

  ccmp_anb_pkg::in_t  item;
  ccmp_anb_pkg::dec_t dec;
  ccmp_anb_pkg::mid_t mid;
  ccmp_anb_pkg::res_t res;
  logic               dec_valid, dec_ready;
  logic               mid_valid, mid_ready;

  // unpack the request, tdata fields from the lowest bit up
  assign item.action           = ccmp_anb_pkg::action_e'(s_axis_tuser);
  assign item.frame_control    = s_axis_tdata[15:0];
  assign item.address_one      = s_axis_tdata[63:16];
  assign item.address_two      = s_axis_tdata[111:64];
  assign item.address_three    = s_axis_tdata[159:112];
  assign item.address_four     = s_axis_tdata[207:160];
  assign item.sequence_control = s_axis_tdata[223:208];
  assign item.qos_control      = s_axis_tdata[239:224];
  assign item.packet_number    = s_axis_tdata[287:240];
  assign item.key_index        = s_axis_tdata[289:288];
  assign item.ccmp_header_in   = s_axis_tdata[353:290];

  // stage one: frame control masking, flags, ccmp header build or parse
  ccmp_anb_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (item),
    .valid_o (dec_valid),
    .ready_i (dec_ready),
    .dec_o   (dec)
  );

  // stage two: aad byte layout and lengths
  ccmp_anb_assemble u_assemble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .dec_i   (dec),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .mid_o   (mid)
  );

  // stage three: nonce byte order, result register facing the master side
  ccmp_anb_output u_output (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .mid_i   (mid),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  // pack the result, first field lowest, top bits zero
  assign m_axis_tdata = {2'b00, res.header_ok, res.parsed_key, res.parsed_number,
                         res.ccmp_header_out, res.header_length, res.nonce_high,
                         res.nonce_low, res.aad_length, res.aad_word3, res.aad_word2,
                         res.aad_word1, res.aad_word0};

endmodule

FILE: src/ccmp_anb_decode.sv
module ccmp_anb_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  ccmp_anb_pkg::in_t item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ccmp_anb_pkg::dec_t dec_o
);

  ccmp_anb_pkg::dec_t          dec_d, dec_q;
  logic                        valid_q;
  ccmp_anb_pkg::frame_type_e   ftype;
  logic [3:0]                  stype;
  logic                        ext_iv;

  always_comb begin
    ftype  = ccmp_anb_pkg::frame_type_e'(item_i.frame_control[3:2]);
    stype  = item_i.frame_control[7:4];
    ext_iv = item_i.ccmp_header_in[29];

    dec_d.four = (item_i.frame_control & ccmp_anb_pkg::FcBothDs) == ccmp_anb_pkg::FcBothDs;
    dec_d.qos  = (ftype == ccmp_anb_pkg::TypeData) &&
                 ((stype & ccmp_anb_pkg::SubtypeQos) != 4'h0);

    // frame control masking
    dec_d.masked_fc = item_i.frame_control;
    if (ftype == ccmp_anb_pkg::TypeData) begin
      dec_d.masked_fc = dec_d.masked_fc & ~ccmp_anb_pkg::FcSubtypeLow;
      if (dec_d.qos) begin
        dec_d.masked_fc = dec_d.masked_fc & ~ccmp_anb_pkg::FcOrder;
      end
    end
    dec_d.masked_fc = (dec_d.masked_fc & ~(ccmp_anb_pkg::FcRetry | ccmp_anb_pkg::FcPwrMgt |
                      ccmp_anb_pkg::FcMoreData)) | ccmp_anb_pkg::FcProtected;

    dec_d.a1   = item_i.address_one;
    dec_d.a2   = item_i.address_two;
    dec_d.a3   = item_i.address_three;
    dec_d.a4   = item_i.address_four;
    dec_d.frag = item_i.sequence_control[3:0];
    dec_d.tid  = item_i.qos_control[3:0];

    if (dec_d.qos) begin
      dec_d.flags = {4'h0, item_i.qos_control[3:0]};
    end else if (ftype == ccmp_anb_pkg::TypeMgmt) begin
      dec_d.flags = ccmp_anb_pkg::MgmtFlags;
    end else begin
      dec_d.flags = 8'h00;
    end

    if (item_i.action == ccmp_anb_pkg::ActRx) begin
      dec_d.hdr_out = 64'h0;
      if (ext_iv) begin
        dec_d.pnum = {item_i.ccmp_header_in[63:32], item_i.ccmp_header_in[15:0]};
        dec_d.pkey = item_i.ccmp_header_in[31:30];
        dec_d.ok   = 1'b1;
      end else begin
        dec_d.pnum = 48'h0;
        dec_d.pkey = 2'd0;
        dec_d.ok   = 1'b0;
      end
      dec_d.pn = dec_d.pnum;
    end else begin
      dec_d.pn      = item_i.packet_number;
      dec_d.hdr_out = {item_i.packet_number[47:16], item_i.key_index, 1'b1, 5'd0, 8'h00,
                       item_i.packet_number[15:0]};
      dec_d.pnum    = 48'h0;
      dec_d.pkey    = 2'd0;
      dec_d.ok      = 1'b1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

FILE: src/ccmp_anb_assemble.sv
module ccmp_anb_assemble (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ccmp_anb_pkg::dec_t dec_i,
  output logic               valid_o,
  input  logic               ready_i,
  output ccmp_anb_pkg::mid_t mid_o
);

  ccmp_anb_pkg::mid_t mid_d, mid_q;
  logic               valid_q;
  logic [63:0]        tail;
  logic [4:0]         len;

  always_comb begin
    // bytes 22..29 depend on four-address and qos
    tail = 64'h0;
    if (dec_i.four) begin
      tail[47:0] = dec_i.a4;
      if (dec_i.qos) begin
        tail[55:48] = {4'h0, dec_i.tid};
      end
    end else if (dec_i.qos) begin
      tail[7:0] = {4'h0, dec_i.tid};
    end

    len = ccmp_anb_pkg::AadBaseLen;
    if (dec_i.four) begin
      len = len + ccmp_anb_pkg::AddrLen;
    end
    if (dec_i.qos) begin
      len = len + ccmp_anb_pkg::QosLen;
    end

    mid_d.aad     = {tail, 8'h00, 4'h0, dec_i.frag, dec_i.a3, dec_i.a2, dec_i.a1,
                     dec_i.masked_fc};
    mid_d.aad_len = len;
    mid_d.hdr_len = {1'b0, len} + ccmp_anb_pkg::HdrExtra;
    mid_d.a2      = dec_i.a2;
    mid_d.flags   = dec_i.flags;
    mid_d.pn      = dec_i.pn;
    mid_d.hdr_out = dec_i.hdr_out;
    mid_d.pnum    = dec_i.pnum;
    mid_d.pkey    = dec_i.pkey;
    mid_d.ok      = dec_i.ok;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      mid_q <= mid_d;
    end
  end

  assign valid_o = valid_q;
  assign mid_o   = mid_q;

endmodule

FILE: src/ccmp_anb_output.sv
module ccmp_anb_output (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ccmp_anb_pkg::mid_t mid_i,
  output logic               valid_o,
  input  logic               ready_i,
  output ccmp_anb_pkg::res_t res_o
);

  ccmp_anb_pkg::res_t res_d, res_q;
  logic               valid_q;

  always_comb begin
    res_d.aad_word0       = mid_i.aad[63:0];
    res_d.aad_word1       = mid_i.aad[127:64];
    res_d.aad_word2       = mid_i.aad[191:128];
    res_d.aad_word3       = mid_i.aad[239:192];
    res_d.aad_length      = mid_i.aad_len;
    // nonce: flags, a2, then pn with its top octet first
    res_d.nonce_low       = {mid_i.pn[47:40], mid_i.a2, mid_i.flags};
    res_d.nonce_high      = {mid_i.pn[7:0], mid_i.pn[15:8], mid_i.pn[23:16],
                             mid_i.pn[31:24], mid_i.pn[39:32]};
    res_d.header_length   = mid_i.hdr_len;
    res_d.ccmp_header_out = mid_i.hdr_out;
    res_d.parsed_number   = mid_i.pnum;
    res_d.parsed_key      = mid_i.pkey;
    res_d.header_ok       = mid_i.ok;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: src/ccmp_anb_checker.sv
`include "ccmp_aad_nonce_builder_assert.svh"

module ccmp_anb_sva (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [ccmp_anb_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [4:0]  aad_len;
  logic [5:0]  hdr_len;
  logic [63:0] hdr_out;
  logic [47:0] pnum;
  logic [1:0]  pkey;
  logic        ok;
  logic        len_ok;
  logic        parse_clear;
  logic        hdr_form;

  assign aad_len     = m_axis_tdata[244:240];
  assign hdr_len     = m_axis_tdata[354:349];
  assign hdr_out     = m_axis_tdata[418:355];
  assign pnum        = m_axis_tdata[466:419];
  assign pkey        = m_axis_tdata[468:467];
  assign ok          = m_axis_tdata[469];
  assign len_ok      = (aad_len inside {5'd22, 5'd24, 5'd28, 5'd30}) &&
                       (hdr_len == {1'b0, aad_len} + 6'd2);
  assign parse_clear = (pnum == 48'h0) && (pkey == 2'd0);
  assign hdr_form    = (hdr_out[29] && parse_clear) || (hdr_out == 64'h0);

  // stalled result holds
  `CCMP_ANB_ASSERT(a_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "result changed under stall")

  // lengths agree and take only the four legal values
  `CCMP_ANB_ASSERT_ON_VALID(a_len, clk_i, rst_ni, m_axis_tvalid, len_ok, "bad aad or header length")

  // a failed parse leaves no pn and no key
  `CCMP_ANB_ASSERT_ON_VALID(a_bad_hdr, clk_i, rst_ni, (m_axis_tvalid && !ok), (parse_clear && (hdr_out == 64'h0)), "parsed fields set without ext iv")

  // a built header always carries ext iv, receive leaves it zero
  `CCMP_ANB_ASSERT_ON_VALID(a_hdr_out, clk_i, rst_ni, m_axis_tvalid, hdr_form, "ccmp header out malformed")

  // with the output register empty the whole pipe can take a request
  `CCMP_ANB_ASSERT(a_ready, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready, "pipe refused a request while empty")

endmodule

bind ccmp_aad_nonce_builder ccmp_anb_sva u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: test/ccmp_anb_checker.sv
`timescale 1ns / 1ps

module ccmp_anb_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  input  logic                              req_ready_i,
  input  logic [ccmp_anb_pkg::InDataW-1:0]  req_data_i,
  input  logic                              req_user_i,
  input  logic                              res_valid_i,
  input  logic                              res_ready_i,
  input  logic [ccmp_anb_pkg::OutDataW-1:0] res_data_i,
  output int                                mismatch_cnt_o,
  output int                                pending_cnt_o,
  output int                                checked_cnt_o
);

  // ext iv bit of ccmp header byte 3
  localparam logic [7:0] ExtIvFlag = 8'h20;

  ccmp_anb_pkg::res_t expected_results[$];

  initial begin
    mismatch_cnt_o = 0;
    pending_cnt_o  = 0;
    checked_cnt_o  = 0;
  end

  function automatic ccmp_anb_pkg::in_t unpack_request(logic [ccmp_anb_pkg::InDataW-1:0] d,
                                                       logic user);
    ccmp_anb_pkg::in_t r;
    r.action           = ccmp_anb_pkg::action_e'(user);
    r.frame_control    = d[15:0];
    r.address_one      = d[63:16];
    r.address_two      = d[111:64];
    r.address_three    = d[159:112];
    r.address_four     = d[207:160];
    r.sequence_control = d[223:208];
    r.qos_control      = d[239:224];
    r.packet_number    = d[287:240];
    r.key_index        = d[289:288];
    r.ccmp_header_in   = d[353:290];
    return r;
  endfunction

  function automatic ccmp_anb_pkg::res_t unpack_result(logic [ccmp_anb_pkg::OutDataW-1:0] d);
    ccmp_anb_pkg::res_t g;
    g.aad_word0       = d[63:0];
    g.aad_word1       = d[127:64];
    g.aad_word2       = d[191:128];
    g.aad_word3       = d[239:192];
    g.aad_length      = d[244:240];
    g.nonce_low       = d[308:245];
    g.nonce_high      = d[348:309];
    g.header_length   = d[354:349];
    g.ccmp_header_out = d[418:355];
    g.parsed_number   = d[466:419];
    g.parsed_key      = d[468:467];
    g.header_ok       = d[469];
    return g;
  endfunction

  // masked aad, nonce and ccmp header handling for one request
  function automatic ccmp_anb_pkg::res_t predict_aad_nonce(ccmp_anb_pkg::in_t r);
    ccmp_anb_pkg::frame_type_e ftype;
    logic                      four;
    logic                      qos;
    logic [15:0]               mfc;
    logic [7:0]                aad [0:29];
    logic [7:0]                flags;
    logic [47:0]               pn;
    logic [63:0]               hdr;
    logic [4:0]                pos;
    ccmp_anb_pkg::res_t        e;
    ftype = ccmp_anb_pkg::frame_type_e'(r.frame_control[3:2]);
    four  = (r.frame_control & ccmp_anb_pkg::FcBothDs) == ccmp_anb_pkg::FcBothDs;
    qos   = (ftype == ccmp_anb_pkg::TypeData) &&
            ((r.frame_control[7:4] & ccmp_anb_pkg::SubtypeQos) != '0);
    mfc   = r.frame_control;
    if (ftype == ccmp_anb_pkg::TypeData) begin
      mfc &= ~ccmp_anb_pkg::FcSubtypeLow;
      if (qos) mfc &= ~ccmp_anb_pkg::FcOrder;
    end
    mfc &= ~(ccmp_anb_pkg::FcRetry | ccmp_anb_pkg::FcPwrMgt | ccmp_anb_pkg::FcMoreData);
    mfc |= ccmp_anb_pkg::FcProtected;

    foreach (aad[i]) aad[i] = 8'h00;
    aad[0] = mfc[7:0];
    aad[1] = mfc[15:8];
    for (int i = 0; i < 6; i++) begin
      aad[2 + i]  = r.address_one[8*i +: 8];
      aad[8 + i]  = r.address_two[8*i +: 8];
      aad[14 + i] = r.address_three[8*i +: 8];
    end
    // only the fragment number survives, then a zero byte
    aad[20] = {4'h0, r.sequence_control[3:0]};
    pos = ccmp_anb_pkg::AadBaseLen;
    if (four) begin
      for (int i = 0; i < 6; i++) aad[pos + i] = r.address_four[8*i +: 8];
      pos += ccmp_anb_pkg::AddrLen;
    end
    if (qos) begin
      aad[pos] = {4'h0, r.qos_control[3:0]};
      pos += ccmp_anb_pkg::QosLen;
    end

    e = '0;
    for (int i = 0; i < 8; i++) begin
      e.aad_word0[8*i +: 8] = aad[i];
      e.aad_word1[8*i +: 8] = aad[8 + i];
      e.aad_word2[8*i +: 8] = aad[16 + i];
    end
    for (int i = 0; i < 6; i++) e.aad_word3[8*i +: 8] = aad[24 + i];
    e.aad_length    = pos;
    e.header_length = {1'b0, pos} + ccmp_anb_pkg::HdrExtra;

    pn  = '0;
    hdr = r.ccmp_header_in;
    if (r.action == ccmp_anb_pkg::ActRx) begin
      // without ext iv nothing is parsed and the nonce takes a zero pn
      if ((hdr[31:24] & ExtIvFlag) != '0) begin
        e.parsed_number = {hdr[63:32], hdr[15:0]};
        e.parsed_key    = hdr[31:30];
        e.header_ok     = 1'b1;
      end
      pn = e.parsed_number;
    end else begin
      pn = r.packet_number;
      e.ccmp_header_out = {pn[47:16], ({r.key_index, 6'b0} | ExtIvFlag), 8'h00, pn[15:0]};
      e.header_ok       = 1'b1;
    end

    if (qos) flags = {4'h0, r.qos_control[3:0]};
    else if (ftype == ccmp_anb_pkg::TypeMgmt) flags = ccmp_anb_pkg::MgmtFlags;
    else flags = 8'h00;

    e.nonce_low  = {pn[47:40], r.address_two, flags};
    e.nonce_high = {pn[7:0], pn[15:8], pn[23:16], pn[31:24], pn[39:32]};
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_cnt_o++;
  endtask

  task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin
    ccmp_anb_pkg::res_t got;
    ccmp_anb_pkg::res_t want;
    if (rst_ni) begin
      if (res_valid_i && res_ready_i) begin
        got = unpack_result(res_data_i);
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", got.aad_word0, '0);
        end else begin
          want = expected_results.pop_front();
          compare_field("aad_word0", got.aad_word0, want.aad_word0);
          compare_field("aad_word1", got.aad_word1, want.aad_word1);
          compare_field("aad_word2", got.aad_word2, want.aad_word2);
          compare_field("aad_word3", 64'(got.aad_word3), 64'(want.aad_word3));
          compare_field("aad_length", 64'(got.aad_length), 64'(want.aad_length));
          compare_field("nonce_low", got.nonce_low, want.nonce_low);
          compare_field("nonce_high", 64'(got.nonce_high), 64'(want.nonce_high));
          compare_field("header_length", 64'(got.header_length), 64'(want.header_length));
          compare_field("ccmp_header_out", got.ccmp_header_out, want.ccmp_header_out);
          compare_field("parsed_number", 64'(got.parsed_number), 64'(want.parsed_number));
          compare_field("parsed_key", 64'(got.parsed_key), 64'(want.parsed_key));
          compare_field("header_ok", 64'(got.header_ok), 64'(want.header_ok));
          checked_cnt_o++;
        end
      end
      if (req_valid_i && req_ready_i)
        expected_results.push_back(predict_aad_nonce(unpack_request(req_data_i, req_user_i)));
      pending_cnt_o = expected_results.size();
    end
  end

endmodule

FILE: test/tb_ccmp_aad_nonce_builder.sv
`timescale 1ns / 1ps

module tb_ccmp_aad_nonce_builder;

  localparam int RandomRequests = 600;
  // final stretch of requests sent with no idling on either side
  localparam int QuietRequests  = 100;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [ccmp_anb_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                              s_axis_tuser  = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [ccmp_anb_pkg::OutDataW-1:0] m_axis_tdata;

  int mismatch_cnt;
  int pending_cnt;
  int checked_cnt;
  int sent_cnt     = 0;
  int directed_cnt = 0;
  bit quiet        = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ccmp_aad_nonce_builder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // watches both channels, predicts every request and compares its result
  ccmp_anb_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_i    (s_axis_tready),
    .req_data_i     (s_axis_tdata),
    .req_user_i     (s_axis_tuser),
    .res_valid_i    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_data_i     (m_axis_tdata),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt),
    .checked_cnt_o  (checked_cnt)
  );

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  // every field random; directed cases override what they aim at
  function automatic ccmp_anb_pkg::in_t random_request();
    ccmp_anb_pkg::in_t r;
    r.action           = $urandom_range(0, 1) ? ccmp_anb_pkg::ActRx : ccmp_anb_pkg::ActTx;
    r.frame_control    = 16'($urandom);
    r.address_one      = rand48();
    r.address_two      = rand48();
    r.address_three    = rand48();
    r.address_four     = rand48();
    r.sequence_control = 16'($urandom);
    r.qos_control      = 16'($urandom);
    r.packet_number    = rand48();
    r.key_index        = 2'($urandom);
    r.ccmp_header_in   = {$urandom, $urandom};
    return r;
  endfunction

  // one request on the slave side, with an occasional idle burst ahead of it
  task automatic send_request(ccmp_anb_pkg::in_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tdata  <= {6'b0, r.ccmp_header_in, r.key_index, r.packet_number, r.qos_control,
                      r.sequence_control, r.address_four, r.address_three, r.address_two,
                      r.address_one, r.frame_control};
    s_axis_tuser  <= r.action;
    s_axis_tvalid <= 1'b1;
    // tready is read before the edge's register updates take effect
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt++;
  endtask

  // master side backpressure: random stall bursts, none in the quiet stretch
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // generous ceiling, far above the slowest legal run
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    ccmp_anb_pkg::in_t r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // management frame, every field zero
    r = '0;
    r.action = ccmp_anb_pkg::ActTx;
    send_request(r);
    // every field at its top value: reserved type, both ds bits, key 3
    r = '1;
    r.action = ccmp_anb_pkg::ActTx;
    send_request(r);
    // receive, all-ones ccmp header, so ext iv is set
    r.action = ccmp_anb_pkg::ActRx;
    send_request(r);
    // receive with ext iv clear: nothing parsed, zero pn in the nonce
    r = random_request();
    r.action = ccmp_anb_pkg::ActRx;
    r.ccmp_header_in[29] = 1'b0;
    send_request(r);
    // plain data frame with retry, pwrmgt and moredata set, subtype bits masked
    r = random_request();
    r.frame_control = 16'h3878;
    send_request(r);
    // qos data with order set, three addresses
    r = random_request();
    r.frame_control = 16'hb088;
    send_request(r);
    // qos data, four addresses: longest aad
    r = random_request();
    r.frame_control = 16'h8388;
    r.qos_control   = 16'hffff;
    send_request(r);
    // four-address non-qos data keeps order
    r = random_request();
    r.frame_control = 16'h8308;
    send_request(r);
    // only tods, then only fromds: still three addresses
    r = random_request();
    r.frame_control = 16'h0108;
    send_request(r);
    r.frame_control = 16'h0208;
    send_request(r);
    // control frame: zero nonce flags, subtype kept
    r = random_request();
    r.frame_control = 16'h7fb4;
    send_request(r);
    // management frame with order and subtype set
    r = random_request();
    r.frame_control = 16'h80d0;
    send_request(r);
    // every key id on transmit
    for (int k = 0; k < 4; k++) begin
      r = random_request();
      r.action    = ccmp_anb_pkg::ActTx;
      r.key_index = 2'(k);
      send_request(r);
    end
    // every key id parsed on receive
    for (int k = 0; k < 4; k++) begin
      r = random_request();
      r.action = ccmp_anb_pkg::ActRx;
      r.ccmp_header_in[31:24] = {2'(k), 6'h20};
      send_request(r);
    end
    // sequence control with fragment bits clear, then set
    r = random_request();
    r.sequence_control = 16'hfff0;
    send_request(r);
    r.sequence_control = 16'h000f;
    send_request(r);
    // receive, four-address qos, ext iv clear
    r = random_request();
    r.action = ccmp_anb_pkg::ActRx;
    r.frame_control = 16'h0388;
    r.ccmp_header_in[29] = 1'b0;
    send_request(r);
    directed_cnt = sent_cnt;

    // ---- random part ----
    // mostly data frames, with a good share of qos data
    for (int n = 0; n < RandomRequests; n++) begin
      if (n == RandomRequests - QuietRequests) quiet = 1'b1;
      r = random_request();
      case ($urandom_range(0, 3))
        1, 2: begin
          r.frame_control[3:2] = ccmp_anb_pkg::TypeData;
          r.frame_control[7]   = 1'b1;
        end
        3: begin
          r.frame_control[3:2] = ccmp_anb_pkg::TypeData;
          r.frame_control[7]   = 1'b0;
        end
        default: ;
      endcase
      // ext iv mostly set on receive
      if (r.action == ccmp_anb_pkg::ActRx && $urandom_range(0, 3) != 0) begin
        r.ccmp_header_in[29] = 1'b1;
      end
      send_request(r);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    // drain, then allow for the pipeline depth
    wait (pending_cnt == 0);
    repeat (10) @(posedge clk_i);

    $display("tb: %0d requests (%0d directed), tx and rx with all frame types, ds and qos mixes",
             sent_cnt, directed_cnt);
    $display("tb: %0d results checked, %0d mismatches", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: ccmp_aad_nonce_builder.f
+incdir+src
src/ccmp_anb_pkg.sv
src/ccmp_anb_decode.sv
src/ccmp_anb_assemble.sv
src/ccmp_anb_output.sv
src/ccmp_aad_nonce_builder.sv
src/ccmp_anb_checker.sv
test/ccmp_anb_checker.sv
test/tb_ccmp_aad_nonce_builder.sv
